// ===== hdl/hdrs_pkg.sv =====
package hdrs_pkg;

    // Item kinds carried on the input tuser
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_SLOT  = 3'd2;
    localparam logic [2:0] MODE_TXEND = 3'd3;
    localparam logic [2:0] MODE_RXBYTE = 3'd4;
    localparam logic [2:0] MODE_TICK  = 3'd5;

    // Session status codes
    localparam logic [1:0] STS_NONE     = 2'd0;
    localparam logic [1:0] STS_OK       = 2'd1;
    localparam logic [1:0] STS_TIMEOUT  = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    // Register indexes on the APB port
    localparam logic [1:0] REG_TERM    = 2'd0;
    localparam logic [1:0] REG_TAIL    = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // Reset values of the registers
    localparam logic [7:0]  TERM_RST    = 8'd0;
    localparam logic [3:0]  TAIL_RST    = 4'd3;
    localparam logic [6:0]  LIMIT_RST   = 7'd50;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TX   = 2'd1,
        PH_RX   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMPTY,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0]  terminator_byte;
        logic [3:0]  tail_count;
        logic [6:0]  answer_limit;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic idx_inc;
        logic emit_empty;
        logic emit_byte;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic close_ok;
        logic ans_zero;
        logic idx_last;
    } t_stat;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       drive_line;
        logic       listening;
        logic       answer_valid;
        logic [7:0] answer_byte;
        logic       answer_last;
        logic [1:0] status;
        logic       session_done;
    } t_result;

endpackage

// ===== hdl/hdrs_ctrl.sv =====
module hdrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hdrs_pkg::t_stat i_stat,
    output hdrs_pkg::t_cmd  o_cmd
);
    import hdrs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_stat.out_free) n_state = i_stat.close_ok ? ST_SCAN_RD : ST_IDLE;
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (!i_stat.ans_zero) n_state = ST_EMIT;
                else if (i_stat.idx_last) n_state = ST_EMPTY;
                else n_state = ST_SCAN_RD;
            end
            ST_EMPTY: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.idx_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            ST_SCAN_CHK: begin
                o_cmd.idx_inc = i_stat.ans_zero && !i_stat.idx_last;
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = i_stat.out_free;
            end
            ST_EMIT: begin
                o_cmd.emit_byte = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/hdrs_dp.sv =====
module hdrs_dp #(
    parameter int MESSAGE_DEPTH = 64,
    parameter int ANSWER_DEPTH  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hdrs_pkg::t_cfg    i_cfg,
    input  hdrs_pkg::t_cmd    i_cmd,
    output hdrs_pkg::t_stat   o_stat,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_data_byte,
    input  logic              i_parity_bad,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output hdrs_pkg::t_result o_res
);
    import hdrs_pkg::*;

    localparam int MLW = $clog2(MESSAGE_DEPTH + 1);
    localparam int MAW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int CW  = $clog2(ANSWER_DEPTH + 1);
    localparam int CAW = $clog2(ANSWER_DEPTH);
    localparam int LW  = (CW > 7) ? CW : 7;

    // Latched item
    logic [2:0] r_mode;
    logic [7:0] r_data;
    logic       r_pbad;

    // Session state
    logic [MLW-1:0] r_mlen,  n_mlen;
    logic [MLW-1:0] r_sidx,  n_sidx;
    logic [CW-1:0]  r_acnt,  n_acnt;
    logic [3:0]     r_tail,  n_tail;
    logic           r_after, n_after;
    t_phase         r_phase, n_phase;
    logic [15:0]    r_ticks, n_ticks;
    logic [1:0]     r_lstat, n_lstat;
    logic [CW-1:0]  r_idx,   n_idx;

    // Stores and their registered read ports
    logic [7:0] r_msg_mem [MESSAGE_DEPTH];
    logic [7:0] r_ans_mem [ANSWER_DEPTH];
    logic [7:0] r_msg_rd;
    logic [7:0] r_ans_rd;
    logic       msg_we;
    logic       ans_we;

    // Output register
    t_result r_out;
    logic    r_ovalid;
    t_result res;
    logic    load_out;

    // Receive byte evaluation
    logic [CW-1:0] cnt_inc;
    logic [LW-1:0] lim;
    logic [LW-1:0] lim_cfg;
    logic          rx_take;
    logic          ovf;
    logic          hit;
    logic [3:0]    tail_inc;
    logic [3:0]    tail_nx;
    logic          tail_done;

    assign cnt_inc  = r_acnt + CW'(1);
    assign lim_cfg  = LW'(i_cfg.answer_limit);
    assign lim      = (lim_cfg == '0) ? LW'(1) :
                      ((lim_cfg > LW'(ANSWER_DEPTH)) ? LW'(ANSWER_DEPTH) : lim_cfg);
    assign rx_take  = (r_mode == MODE_RXBYTE) && (r_phase == PH_RX) && !r_pbad;
    assign ovf      = LW'(cnt_inc) >= lim;
    assign hit      = (r_data == i_cfg.terminator_byte) || r_after;
    assign tail_inc = (r_tail == 4'hF) ? r_tail : r_tail + 4'd1;
    assign tail_nx  = hit ? tail_inc : r_tail;
    assign tail_done = (i_cfg.tail_count != 4'd0) && (tail_nx == i_cfg.tail_count);

    assign o_stat.out_free = !r_ovalid || i_res_ready;
    assign o_stat.close_ok = rx_take && !ovf && tail_done;
    assign o_stat.ans_zero = (r_ans_rd == 8'd0);
    assign o_stat.idx_last = ((r_idx + CW'(1)) == r_acnt);

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    // Item execution, answer walk and result build
    always_comb begin
        logic       do_close;
        logic [1:0] close_st;
        n_mlen   = r_mlen;
        n_sidx   = r_sidx;
        n_acnt   = r_acnt;
        n_tail   = r_tail;
        n_after  = r_after;
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_lstat  = r_lstat;
        n_idx    = r_idx;
        msg_we   = 1'b0;
        ans_we   = 1'b0;
        load_out = 1'b0;
        do_close = 1'b0;
        close_st = STS_NONE;
        res      = '0;

        if (i_cmd.exec) begin
            load_out = 1'b1;
            n_idx    = '0;
            case (r_mode)
                MODE_LOAD: begin
                    if (r_phase == PH_IDLE && r_mlen < MLW'(MESSAGE_DEPTH)) begin
                        msg_we = 1'b1;
                        n_mlen = r_mlen + MLW'(1);
                    end
                end
                MODE_START: begin
                    if (r_phase == PH_IDLE && r_mlen != '0) begin
                        n_phase = PH_TX;
                        n_sidx  = '0;
                        n_acnt  = '0;
                        n_tail  = 4'd0;
                        n_after = 1'b0;
                        n_ticks = 16'd0;
                        n_lstat = STS_NONE;
                    end
                end
                MODE_SLOT: begin
                    if (r_phase == PH_TX && r_sidx < r_mlen) begin
                        n_sidx       = r_sidx + MLW'(1);
                        res.tx_valid = 1'b1;
                        res.tx_byte  = r_msg_rd;
                    end
                end
                MODE_TXEND: begin
                    if (r_phase == PH_TX) begin
                        n_phase = PH_RX;
                        n_ticks = i_cfg.timeout_ticks;
                    end
                end
                MODE_RXBYTE: begin
                    if (rx_take) begin
                        ans_we = 1'b1;
                        n_acnt = cnt_inc;
                        if (ovf) begin
                            do_close = 1'b1;
                            close_st = STS_OVERFLOW;
                        end else begin
                            n_after = hit;
                            n_tail  = tail_nx;
                            if (tail_done) begin
                                do_close = 1'b1;
                                close_st = STS_OK;
                                load_out = 1'b0;
                            end
                        end
                    end
                end
                MODE_TICK: begin
                    if (r_phase == PH_RX) begin
                        if (r_ticks <= 16'd1) begin
                            do_close = 1'b1;
                            close_st = STS_TIMEOUT;
                        end else begin
                            n_ticks = r_ticks - 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (do_close) begin
                n_phase = PH_IDLE;
                n_mlen  = '0;
                n_sidx  = '0;
                n_ticks = 16'd0;
                n_lstat = close_st;
                res.session_done = 1'b1;
            end
        end

        // Leading zero skip and answer emission
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end
        if (i_cmd.emit_empty) begin
            load_out         = 1'b1;
            res.session_done = 1'b1;
        end
        if (i_cmd.emit_byte) begin
            load_out         = 1'b1;
            n_idx            = r_idx + CW'(1);
            res.answer_valid = 1'b1;
            res.answer_byte  = r_ans_rd;
            res.answer_last  = o_stat.idx_last;
            res.session_done = o_stat.idx_last;
        end

        res.drive_line = (n_phase == PH_TX);
        res.listening  = (n_phase == PH_RX);
        res.status     = n_lstat;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlen   <= '0;
            r_sidx   <= '0;
            r_acnt   <= '0;
            r_tail   <= 4'd0;
            r_after  <= 1'b0;
            r_phase  <= PH_IDLE;
            r_ticks  <= 16'd0;
            r_lstat  <= STS_NONE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_mlen  <= n_mlen;
            r_sidx  <= n_sidx;
            r_acnt  <= n_acnt;
            r_tail  <= n_tail;
            r_after <= n_after;
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_lstat <= n_lstat;
            r_idx   <= n_idx;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_data <= i_data_byte;
            r_pbad <= i_parity_bad;
        end
        if (load_out) begin
            r_out <= res;
        end
    end

    // Message store: written on load, read at the send index
    always_ff @(posedge i_clk) begin
        if (msg_we) begin
            r_msg_mem[r_mlen[MAW-1:0]] <= r_data;
        end
        r_msg_rd <= r_msg_mem[r_sidx[MAW-1:0]];
    end

    // Answer store: written on a good received byte, read at the walk index
    always_ff @(posedge i_clk) begin
        if (ans_we) begin
            r_ans_mem[r_acnt[CAW-1:0]] <= r_data;
        end
        r_ans_rd <= r_ans_mem[r_idx[CAW-1:0]];
    end

endmodule

// ===== hdl/half_duplex_request_response_session_core.sv =====
// Half-duplex request/response session core. Each input word is one event (load, start,
// transmit slot, transmit complete, received byte, tick) and yields at least one result
// word reporting the direction line and receive phase; a transmit slot result carries the
// byte to send. An ordinary event is latched, then executed once the output register is
// free; the next word is accepted while the previous result still waits. On a successful
// close the answer store is walked through its single registered read port: leading zero
// bytes are read and skipped, then answer bytes read and emitted, the last marked by tlast.
// Registers are to be written through the APB port only while no session event is in
// flight; the user must keep to this, as the block itself does not enforce it.
module half_duplex_request_response_session_core #(
    parameter int MESSAGE_DEPTH = 64,
    parameter int ANSWER_DEPTH  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Event stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]  i_s_axis_tuser,   // [2:0] mode, [3] parity_bad
    // Result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] tx_byte, [8] drive_line, [9] listening,
                                          // [17:10] answer_byte, [19:18] status,
                                          // [20] session_done, [23:21] zero
    output logic [1:0]  o_m_axis_tuser,   // [0] tx_valid, [1] answer_valid
    output logic        o_m_axis_tlast    // answer_last
);
    import hdrs_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.terminator_byte <= TERM_RST;
            r_cfg.tail_count      <= TAIL_RST;
            r_cfg.answer_limit    <= LIMIT_RST;
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_TERM:    r_cfg.terminator_byte <= pwdata[7:0];
                REG_TAIL:    r_cfg.tail_count      <= pwdata[3:0];
                REG_LIMIT:   r_cfg.answer_limit    <= pwdata[6:0];
                REG_TIMEOUT: r_cfg.timeout_ticks   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_TERM:    prdata = {24'd0, r_cfg.terminator_byte};
            REG_TAIL:    prdata = {28'd0, r_cfg.tail_count};
            REG_LIMIT:   prdata = {25'd0, r_cfg.answer_limit};
            REG_TIMEOUT: prdata = {16'd0, r_cfg.timeout_ticks};
            default:     prdata = 32'd0;
        endcase
    end

    hdrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hdrs_dp #(
        .MESSAGE_DEPTH (MESSAGE_DEPTH),
        .ANSWER_DEPTH  (ANSWER_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_s_axis_tuser[2:0]),
        .i_data_byte  (i_s_axis_tdata),
        .i_parity_bad (i_s_axis_tuser[3]),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res)
    );

    // Result word packing
    assign o_m_axis_tdata = {3'd0, res.session_done, res.status, res.answer_byte,
                             res.listening, res.drive_line, res.tx_byte};
    assign o_m_axis_tuser = {res.answer_valid, res.tx_valid};
    assign o_m_axis_tlast = res.answer_last;

endmodule
